// File: rtl/bounded_ordered_list_engine_assert.svh
// Assertion macros for the ordered list engine.
`ifndef BOUNDED_ORDERED_LIST_ENGINE_ASSERT_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define BOLE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked on every rising clock edge outside reset.
`define BOLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/bole_pkg.sv
// ----------------------------------------------------------------------------
// bole_pkg
// Shared types, codes and sizes of the ordered list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package bole_pkg;

   localparam int Depth = 256;
   localparam int AddrW = $clog2(Depth);
   localparam int CountW = AddrW + 1;

   typedef enum logic [2:0] {
      OP_PUSH   = 3'd0,
      OP_POP    = 3'd1,
      OP_INSERT = 3'd2,
      OP_ERASE  = 3'd3,
      OP_FIND   = 3'd4,
      OP_READ   = 3'd5,
      OP_SORT   = 3'd6,
      OP_NONE   = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_BAD_INDEX = 3'd2,
      ST_FULL      = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   typedef struct packed {
      logic [2:0]         op;
      logic signed [31:0] value;
      logic [8:0]         position;
   } req_type;

   typedef struct packed {
      logic signed [31:0] data_out;
      logic [7:0]         found_index;
      logic [8:0]         count_out;
      logic [2:0]         status;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SHUP_RD,
      S_SHUP_WR,
      S_SHDN_RD,
      S_SHDN_WR,
      S_FIND,
      S_READ,
      S_SORT_HELD,
      S_SORT_CMP,
      S_SORT_PUT,
      S_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                rd_en;
      logic [AddrW-1:0]    rd_addr;
      logic                wr_en;
      logic [AddrW-1:0]    wr_addr;
      logic                wr_sel_val;  // write the request value instead of the read register
      logic                wr_sel_held; // write the held sort word
      logic                held_load;
      logic                data_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic rd_eq_val;
      logic held_lt_rd;
   } stat_type;

endpackage

`default_nettype wire

// File: rtl/bole_datapath.sv
// ----------------------------------------------------------------------------
// bole_datapath
// Entry memory, read register, sort hold and data registers, and comparators.
// ----------------------------------------------------------------------------
`default_nettype none

module bole_datapath (
   input  wire logic               clock,
   input  wire bole_pkg::cmd_type  cmd,
   input  wire logic signed [31:0] value,
   output      bole_pkg::stat_type stat,
   output      logic signed [31:0] data_hold
);

   logic signed [31:0] mem [bole_pkg::Depth];
   logic signed [31:0] rd_ff;
   logic signed [31:0] held_ff;
   logic signed [31:0] data_ff;
   logic signed [31:0] wr_data;

   always_comb begin
      if (cmd.wr_sel_held) begin
         wr_data = held_ff;
      end else if (cmd.wr_sel_val) begin
         wr_data = value;
      end else begin
         wr_data = rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[cmd.rd_addr];
      end
      if (cmd.held_load) begin
         held_ff <= rd_ff;
      end
      if (cmd.data_load) begin
         data_ff <= rd_ff;
      end
   end

   assign stat.rd_eq_val  = (rd_ff == value);
   assign stat.held_lt_rd = (held_ff < rd_ff);
   assign data_hold = data_ff;

endmodule

`default_nettype wire

// File: rtl/bole_control.sv
// ----------------------------------------------------------------------------
// bole_control
// Command sequencer: walks the store for shifts, searches and the sort.
// ----------------------------------------------------------------------------
`default_nettype none

module bole_control (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire bole_pkg::req_type  req_data,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      bole_pkg::rsp_type  rsp_data,
   input  wire logic [8:0]         cap_limit,
   output      bole_pkg::cmd_type  cmd,
   input  wire bole_pkg::stat_type stat,
   input  wire logic signed [31:0] data_hold,
   output      logic signed [31:0] value_q
);

   localparam int AW = bole_pkg::AddrW;
   localparam int CW = bole_pkg::CountW;

   bole_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       i_ff, i_in;
   logic [CW-1:0]       j_ff, j_in;
   logic [CW-1:0]       pos_ff, pos_in;
   logic signed [31:0]  val_ff, val_in;
   logic [2:0]          op_ff, op_in;
   logic [2:0]          st_ff, st_in;
   logic [7:0]          found_ff, found_in;
   logic                use_data_ff, use_data_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]       cap_eff;
   logic [CW-1:0]       req_pos;

   assign cap_eff = (cap_limit > 9'(bole_pkg::Depth)) ? CW'(bole_pkg::Depth) : CW'(cap_limit);
   assign req_pos = CW'(req_data.position);
   assign value_q = val_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bole_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff        <= i_in;
      j_ff        <= j_in;
      pos_ff      <= pos_in;
      val_ff      <= val_in;
      op_ff       <= op_in;
      st_ff       <= st_in;
      found_ff    <= found_in;
      use_data_ff <= use_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      op_in        = op_ff;
      st_in        = st_ff;
      found_in     = found_ff;
      use_data_in  = use_data_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         bole_pkg::S_IDLE: begin
            req_stall = rsp_valid_ff && rsp_stall;
            if (req_valid && !req_stall) begin
               val_in      = req_data.value;
               op_in       = req_data.op;
               pos_in      = req_pos;
               st_in       = bole_pkg::ST_OK;
               found_in    = '0;
               use_data_in = 1'b0;
               state_in    = bole_pkg::S_DONE;
               unique case (bole_pkg::op_type'(req_data.op))
                  bole_pkg::OP_PUSH: begin
                     if (count_ff >= cap_eff) begin
                        st_in = bole_pkg::ST_FULL;
                     end else begin
                        i_in     = count_ff;
                        pos_in   = count_ff;
                        state_in = bole_pkg::S_SHUP_RD;
                     end
                  end
                  bole_pkg::OP_POP: begin
                     if (count_ff == '0) begin
                        st_in = bole_pkg::ST_EMPTY;
                     end else begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_addr = AW'(count_ff - 1'b1);
                        count_in    = count_ff - 1'b1;
                        use_data_in = 1'b1;
                        state_in    = bole_pkg::S_READ;
                     end
                  end
                  bole_pkg::OP_INSERT: begin
                     if (req_pos > count_ff) begin
                        st_in = bole_pkg::ST_BAD_INDEX;
                     end else if (count_ff >= cap_eff) begin
                        st_in = bole_pkg::ST_FULL;
                     end else begin
                        i_in     = count_ff;
                        state_in = bole_pkg::S_SHUP_RD;
                     end
                  end
                  bole_pkg::OP_ERASE: begin
                     if (count_ff == '0) begin
                        st_in = bole_pkg::ST_EMPTY;
                     end else if (req_pos >= count_ff) begin
                        st_in = bole_pkg::ST_BAD_INDEX;
                     end else begin
                        i_in     = req_pos;
                        state_in = bole_pkg::S_SHDN_RD;
                     end
                  end
                  bole_pkg::OP_FIND: begin
                     st_in = bole_pkg::ST_NOT_FOUND;
                     if (count_ff != '0) begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_addr = '0;
                        i_in        = '0;
                        state_in    = bole_pkg::S_FIND;
                     end
                  end
                  bole_pkg::OP_READ: begin
                     if (req_pos >= count_ff) begin
                        st_in = bole_pkg::ST_BAD_INDEX;
                     end else begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_addr = AW'(req_pos);
                        use_data_in = 1'b1;
                        state_in    = bole_pkg::S_READ;
                     end
                  end
                  bole_pkg::OP_SORT: begin
                     if (count_ff > CW'(1)) begin
                        i_in        = CW'(1);
                        cmd.rd_en   = 1'b1;
                        cmd.rd_addr = AW'(1);
                        state_in    = bole_pkg::S_SORT_HELD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         bole_pkg::S_READ: begin
            cmd.data_load = 1'b1;
            state_in      = bole_pkg::S_DONE;
         end
         // Insert: move entry i-1 to i while i > pos, then write the value.
         bole_pkg::S_SHUP_RD: begin
            if (i_ff > pos_ff) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = AW'(i_ff - 1'b1);
               state_in    = bole_pkg::S_SHUP_WR;
            end else begin
               cmd.wr_en      = 1'b1;
               cmd.wr_sel_val = 1'b1;
               cmd.wr_addr    = AW'(pos_ff);
               count_in       = count_ff + 1'b1;
               state_in       = bole_pkg::S_DONE;
            end
         end
         bole_pkg::S_SHUP_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = AW'(i_ff);
            i_in        = i_ff - 1'b1;
            state_in    = bole_pkg::S_SHUP_RD;
         end
         // Erase: move entry i+1 to i while i+1 < count.
         bole_pkg::S_SHDN_RD: begin
            if (i_ff + 1'b1 < count_ff) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = AW'(i_ff + 1'b1);
               state_in    = bole_pkg::S_SHDN_WR;
            end else begin
               count_in = count_ff - 1'b1;
               state_in = bole_pkg::S_DONE;
            end
         end
         bole_pkg::S_SHDN_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = AW'(i_ff);
            i_in        = i_ff + 1'b1;
            state_in    = bole_pkg::S_SHDN_RD;
         end
         bole_pkg::S_FIND: begin
            if (stat.rd_eq_val) begin
               st_in    = bole_pkg::ST_OK;
               found_in = i_ff[7:0];
               state_in = bole_pkg::S_DONE;
            end else if (i_ff + 1'b1 < count_ff) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = AW'(i_ff + 1'b1);
               i_in        = i_ff + 1'b1;
            end else begin
               state_in = bole_pkg::S_DONE;
            end
         end
         // Sort: entry i is in the read register; keep it and read entry i-1.
         bole_pkg::S_SORT_HELD: begin
            cmd.held_load = 1'b1;
            cmd.rd_en     = 1'b1;
            cmd.rd_addr   = AW'(i_ff - 1'b1);
            j_in          = i_ff;
            state_in      = bole_pkg::S_SORT_CMP;
         end
         bole_pkg::S_SORT_CMP: begin
            if (stat.held_lt_rd) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_addr = AW'(j_ff);
               j_in        = j_ff - 1'b1;
               if (j_ff > CW'(1)) begin
                  cmd.rd_en   = 1'b1;
                  cmd.rd_addr = AW'(j_ff - CW'(2));
               end else begin
                  state_in = bole_pkg::S_SORT_PUT;
               end
            end else begin
               state_in = bole_pkg::S_SORT_PUT;
            end
         end
         bole_pkg::S_SORT_PUT: begin
            cmd.wr_en       = 1'b1;
            cmd.wr_sel_held = 1'b1;
            cmd.wr_addr     = AW'(j_ff);
            if (i_ff + 1'b1 < count_ff) begin
               i_in        = i_ff + 1'b1;
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = AW'(i_ff + 1'b1);
               state_in    = bole_pkg::S_SORT_HELD;
            end else begin
               state_in = bole_pkg::S_DONE;
            end
         end
         bole_pkg::S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               state_in     = bole_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bole_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == bole_pkg::S_DONE && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_data.data_out    <= use_data_ff ? data_hold : 32'sd0;
         rsp_data.found_index <= found_ff;
         rsp_data.count_out   <= 9'(count_ff);
         rsp_data.status      <= st_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: rtl/bounded_ordered_list_engine.sv
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine
// List of signed words with push, pop, insert, erase, find, read and sort.
// ----------------------------------------------------------------------------
// One request is taken at a time on req_valid / req_stall and gives exactly
// one response on rsp_valid / rsp_stall, held stable while rsp_stall is high.
// The csr port writes the capacity limit; write it only while idle.
// Requests walk the entry memory, which has one read and one write port:
// failing requests go straight to the response, find reads the entries in
// turn, insert and erase read and then write each shifted entry, and sort
// compares and moves one entry at a time.
// A new request is taken once the previous response has been issued, unless
// that response is still held in the output register by a stall.
// Synchronous reset empties the list and sets the limit to 256; the memory
// itself is not cleared. A stalled receiver holds the response and the
// engine stops before issuing the next one.
`default_nettype none

module bounded_ordered_list_engine (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire bole_pkg::req_type req_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      bole_pkg::rsp_type rsp_data,
   input  wire logic              csr_write_enable,
   input  wire logic [8:0]        csr_write_data
);

   logic [8:0]         cap_ff;
   bole_pkg::cmd_type  cmd;
   bole_pkg::stat_type stat;
   logic signed [31:0] data_hold;
   logic signed [31:0] value_q;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= 9'd256;
      end else if (csr_write_enable) begin
         cap_ff <= csr_write_data;
      end
   end

   bole_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cap_limit (cap_ff),
      .cmd       (cmd),
      .stat      (stat),
      .data_hold (data_hold),
      .value_q   (value_q)
   );

   bole_datapath u_datapath (
      .clock     (clock),
      .cmd       (cmd),
      .value     (value_q),
      .stat      (stat),
      .data_hold (data_hold)
   );

`include "bounded_ordered_list_engine_assert.svh"

   `BOLE_ASSERT_IMPL(a_no_double_write, clock, reset, cmd.wr_sel_held, !cmd.wr_sel_val, "Two write sources selected.")
   `BOLE_ASSERT_NEXT(a_rsp_after_take, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "Stalled response changed.")
   `BOLE_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, rsp_data.count_out <= 9'd256 || !rsp_valid, "Count above store depth.")

endmodule

`default_nettype wire

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the ordered list engine. A scoreboard keeps its
// own copy of the list and the capacity limit, predicts the response to every
// accepted request and compares each response field by field. Stimulus is a
// directed opening followed by random commands over several capacity settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

class list_scoreboard;
   logic signed [31:0] words [256];
   int unsigned        count;
   int unsigned        cap;
   bole_pkg::rsp_type  pending [$];
   int                 errors;

   function new();
      count = 0;
      cap = 256;
      errors = 0;
   endfunction

   function void set_cap(logic [8:0] v);
      cap = {23'd0, v};
   endfunction

   function void note_request(bole_pkg::req_type r);
      bole_pkg::rsp_type e;
      int unsigned       lim;
      int unsigned       i;
      int unsigned       j;
      logic signed [31:0] held;
      e = '0;
      e.status = bole_pkg::ST_OK;
      lim = (cap > 256) ? 256 : cap;
      case (bole_pkg::op_type'(r.op))
         bole_pkg::OP_PUSH: begin
            if (count >= lim) e.status = bole_pkg::ST_FULL;
            else begin
               words[count] = r.value;
               count++;
            end
         end
         bole_pkg::OP_POP: begin
            if (count == 0) e.status = bole_pkg::ST_EMPTY;
            else begin
               count--;
               e.data_out = words[count];
            end
         end
         bole_pkg::OP_INSERT: begin
            if (r.position > count) e.status = bole_pkg::ST_BAD_INDEX;
            else if (count >= lim) e.status = bole_pkg::ST_FULL;
            else begin
               for (i = count; i > r.position; i--) words[i] = words[i-1];
               words[r.position] = r.value;
               count++;
            end
         end
         bole_pkg::OP_ERASE: begin
            if (count == 0) e.status = bole_pkg::ST_EMPTY;
            else if (r.position >= count) e.status = bole_pkg::ST_BAD_INDEX;
            else begin
               for (i = r.position; i + 1 < count; i++) words[i] = words[i+1];
               count--;
            end
         end
         bole_pkg::OP_FIND: begin
            e.status = bole_pkg::ST_NOT_FOUND;
            for (i = 0; i < count; i++) begin
               if (words[i] == r.value) begin
                  e.found_index = i[7:0];
                  e.status = bole_pkg::ST_OK;
                  break;
               end
            end
         end
         bole_pkg::OP_READ: begin
            if (r.position >= count) e.status = bole_pkg::ST_BAD_INDEX;
            else e.data_out = words[r.position];
         end
         bole_pkg::OP_SORT: begin
            for (i = 1; i < count; i++) begin
               held = words[i];
               j = i;
               while (j > 0 && held < words[j-1]) begin
                  words[j] = words[j-1];
                  j--;
               end
               words[j] = held;
            end
         end
         default: ;
      endcase
      e.count_out = count[8:0];
      pending = {pending, e};
   endfunction

   task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch on %s: got %0h, expected %0h", what, got, want);
      errors++;
   endtask

   task check_response(bole_pkg::rsp_type r);
      bole_pkg::rsp_type e;
      if (pending.size() == 0) begin
         $display("response with no request outstanding");
         errors++;
         return;
      end
      e = pending.pop_front();
      if (r.data_out !== e.data_out) report("data_out", r.data_out, e.data_out);
      if (r.found_index !== e.found_index)
         report("found_index", {24'd0, r.found_index}, {24'd0, e.found_index});
      if (r.count_out !== e.count_out)
         report("count_out", {23'd0, r.count_out}, {23'd0, e.count_out});
      if (r.status !== e.status)
         report("status", {29'd0, r.status}, {29'd0, e.status});
   endtask
endclass

module tb;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   bole_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   bole_pkg::rsp_type rsp_data;
   logic              csr_write_enable = 1'b0;
   logic [8:0]        csr_write_data = '0;
   int                cycles = 0;
   int unsigned       rsp_wait = 0;
   list_scoreboard    sb;

   always #5 clock = ~clock;

   bounded_ordered_list_engine u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Receiver: checks accepted responses and, after each one, stalls the next
   // response for a random number of cycles.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_response(rsp_data);
            rsp_wait = $urandom_range(0, 11);
         end else if (rsp_valid && rsp_stall && rsp_wait != 0) begin
            rsp_wait--;
         end
         rsp_stall <= (rsp_wait != 0);
      end
   end

   task automatic send_request(bole_pkg::op_type op, logic [31:0] value,
                               logic [8:0] position);
      int unsigned gap;
      bole_pkg::req_type r;
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      r.op = op;
      r.value = value;
      r.position = position;
      req_data <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(r);
   endtask

   task automatic write_capacity(logic [8:0] v);
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_data <= v;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_cap(v);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(0, 7);
         3: return -$urandom_range(0, 7);
         default: return $urandom;
      endcase
   endfunction

   task automatic random_phase(int unsigned n, int unsigned fill);
      int unsigned k;
      int unsigned c;
      bole_pkg::op_type op;
      logic [8:0] pos;
      for (k = 0; k < n; k++) begin
         c = sb.count;
         case ($urandom_range(0, 13))
            0, 1, 2: op = (c < fill) ? bole_pkg::OP_PUSH : bole_pkg::OP_POP;
            3: op = bole_pkg::OP_POP;
            4, 5: op = bole_pkg::OP_INSERT;
            6: op = bole_pkg::OP_ERASE;
            7, 8: op = bole_pkg::OP_FIND;
            9, 10: op = bole_pkg::OP_READ;
            11: op = (c <= 24) ? bole_pkg::OP_SORT : bole_pkg::OP_READ;
            12: op = bole_pkg::OP_NONE;
            default: op = bole_pkg::op_type'($urandom_range(0, 7));
         endcase
         if (op == bole_pkg::OP_SORT && c > 24) op = bole_pkg::OP_FIND;
         case ($urandom_range(0, 7))
            0: pos = 9'($urandom);
            1: pos = c[8:0];
            2: pos = c[8:0] + 9'd1;
            default: pos = (c == 0) ? 9'd0 : 9'($urandom_range(0, c - 1));
         endcase
         if (op == bole_pkg::OP_FIND && c > 0 && $urandom_range(0, 1))
            send_request(op, sb.words[$urandom_range(0, c - 1)], pos);
         else
            send_request(op, pick_value(), pos);
      end
   endtask

   initial begin
      int unsigned k;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(bole_pkg::OP_POP, 0, 9'd0);
      send_request(bole_pkg::OP_ERASE, 0, 9'd0);
      send_request(bole_pkg::OP_READ, 0, 9'd0);
      send_request(bole_pkg::OP_FIND, 5, 9'd0);
      send_request(bole_pkg::OP_INSERT, 1, 9'd1);
      send_request(bole_pkg::OP_SORT, 0, 9'd0);
      send_request(bole_pkg::OP_PUSH, 32'h7fff_ffff, 9'd0);
      send_request(bole_pkg::OP_PUSH, 32'h8000_0000, 9'd0);
      send_request(bole_pkg::OP_INSERT, 32'hffff_ffff, 9'd1);
      send_request(bole_pkg::OP_INSERT, 0, 9'd3);
      send_request(bole_pkg::OP_INSERT, 7, 9'd0);
      send_request(bole_pkg::OP_FIND, 32'hffff_ffff, 9'd0);
      send_request(bole_pkg::OP_READ, 0, 9'h1ff);
      send_request(bole_pkg::OP_ERASE, 0, 9'd5);
      send_request(bole_pkg::OP_NONE, 32'hffff_ffff, 9'h1ff);
      send_request(bole_pkg::OP_SORT, 0, 9'd0);
      send_request(bole_pkg::OP_READ, 0, 9'd0);
      send_request(bole_pkg::OP_READ, 0, 9'd4);
      send_request(bole_pkg::OP_ERASE, 0, 9'd1);
      send_request(bole_pkg::OP_POP, 0, 9'd0);

      write_capacity(9'd0);
      send_request(bole_pkg::OP_PUSH, 1, 9'd0);
      send_request(bole_pkg::OP_INSERT, 1, 9'd0);
      send_request(bole_pkg::OP_POP, 0, 9'd0);
      write_capacity(9'd2);
      random_phase(120, 3);
      write_capacity(9'd1);
      random_phase(60, 2);
      write_capacity(9'h1ff);
      for (k = sb.count; k < 256; k++) send_request(bole_pkg::OP_PUSH, $urandom, 9'd0);
      send_request(bole_pkg::OP_PUSH, 0, 9'd0);
      send_request(bole_pkg::OP_INSERT, 0, 9'd256);
      send_request(bole_pkg::OP_INSERT, 0, 9'd257);
      send_request(bole_pkg::OP_FIND, 32'h1234_5678, 9'd0);
      send_request(bole_pkg::OP_READ, 0, 9'd255);
      send_request(bole_pkg::OP_ERASE, 0, 9'd0);
      send_request(bole_pkg::OP_INSERT, 3, 9'd0);
      write_capacity(9'd20);
      random_phase(40, 30);
      while (sb.count > 10) send_request(bole_pkg::OP_POP, 0, 9'd0);
      write_capacity(9'd256);
      random_phase(60, 20);
      write_capacity(9'd12);
      random_phase(120, 14);
      req_valid <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule

`default_nettype wire
